// ----- rtl/via_timer_interrupt_registers_assert.svh -----
// ---------------------------------------------------------------------------
// VIA timer register block assertion macros
// Clocked property checks that compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef VIA_TIMER_INTERRUPT_REGISTERS_ASSERT_SVH
`define VIA_TIMER_INTERRUPT_REGISTERS_ASSERT_SVH

`ifndef SYNTHESIS
`define VTIR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VTIR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define VTIR_ASSERT(name, prop, msg)
`define VTIR_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- rtl/vtir_pkg.sv -----
// ---------------------------------------------------------------------------
// VIA timer register block package
// Shared types, register numbers and flag positions.
// ---------------------------------------------------------------------------
`default_nettype none

package vtir_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_RUN   = 3'b010,
    PH_FIRED = 3'b100
  } phase_e;

  localparam logic [3:0] REG_PORT_B     = 4'd0;
  localparam logic [3:0] REG_PORT_A     = 4'd1;
  localparam logic [3:0] REG_DIR_B      = 4'd2;
  localparam logic [3:0] REG_DIR_A      = 4'd3;
  localparam logic [3:0] REG_T1_LOW     = 4'd4;
  localparam logic [3:0] REG_T1_HIGH    = 4'd5;
  localparam logic [3:0] REG_T1_LL      = 4'd6;
  localparam logic [3:0] REG_T1_LH      = 4'd7;
  localparam logic [3:0] REG_T2_LOW     = 4'd8;
  localparam logic [3:0] REG_T2_HIGH    = 4'd9;
  localparam logic [3:0] REG_SHIFT      = 4'd10;
  localparam logic [3:0] REG_AUX        = 4'd11;
  localparam logic [3:0] REG_PERIPH     = 4'd12;
  localparam logic [3:0] REG_FLAGS      = 4'd13;
  localparam logic [3:0] REG_ENABLES    = 4'd14;
  localparam logic [3:0] REG_PORT_A_ALT = 4'd15;

  localparam int unsigned FLAG_W      = 7;
  localparam int unsigned FLAG_T1_BIT = 6;
  localparam int unsigned FLAG_T2_BIT = 5;

  typedef struct packed {
    action_e    action;
    logic [3:0] reg_index;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/via_timer_interrupt_registers.sv -----
// ---------------------------------------------------------------------------
// VIA timer register block
// Sixteen byte registers with two one-shot timers and an interrupt line.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request: a register
//   read, a register write or one timer tick (action_i, reg_index_i,
//   write_data_i). Output channel (out_valid_o / out_ready_i) returns one
//   response per request: read_data_o and the interrupt level irq_o.
//   An accepted request waits in the request register, which feeds the
//   register file; its result loads the response register once that
//   register is free. Throughput is one request per cycle while the
//   receiver does not stall; the request register takes a new request
//   while the response register still holds a result, as long as that
//   result leaves in the same cycle.
//   Reset clears every core register, stops both timers, drops both valids.
//   When the receiver stalls, the response is held, the request register
//   fills, and in_ready_o falls until out_ready_i returns.
// ---------------------------------------------------------------------------
`default_nettype none

module via_timer_interrupt_registers import vtir_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire logic [3:0] reg_index_i,
  input  wire logic [7:0] write_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o,
  output logic            irq_o
);

  logic req_valid;
  req_t req;
  res_t res;
  logic free;
  logic fire;

  assign fire = req_valid && free;

  vtir_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .advance_i    (free),
    .req_valid_o  (req_valid),
    .req_o        (req)
  );

  vtir_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req),
    .res_o  (res)
  );

  vtir_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .irq_o       (irq_o)
  );

endmodule

`default_nettype wire

// ----- rtl/vtir_in_stage.sv -----
// ---------------------------------------------------------------------------
// VIA timer register block input stage
// Registers one request and holds it until the core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module vtir_in_stage import vtir_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire logic [3:0] reg_index_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic       advance_i,
  output logic            req_valid_o,
  output req_t            req_o
);

  logic valid_d, valid_q;
  req_t req_q;
  logic take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q.action     <= action_e'(action_i);
      req_q.reg_index  <= reg_index_i;
      req_q.write_data <= write_data_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

`default_nettype wire

// ----- rtl/vtir_core.sv -----
// ---------------------------------------------------------------------------
// VIA timer register block core
// Register file, two one-shot timers and interrupt flags.
// ---------------------------------------------------------------------------
`default_nettype none
`include "via_timer_interrupt_registers_assert.svh"

module vtir_core import vtir_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  wire req_t req_i,
  output res_t      res_o
);

  logic [7:0] port_b_q, port_b_d, port_a_q, port_a_d;
  logic [7:0] dir_b_q, dir_b_d, dir_a_q, dir_a_d;
  logic [7:0] t1_ll_q, t1_ll_d, t1_lh_q, t1_lh_d, t2_ll_q, t2_ll_d;
  logic [15:0] t1_cnt_q, t1_cnt_d, t2_cnt_q, t2_cnt_d;
  phase_e t1_ph_q, t1_ph_d, t2_ph_q, t2_ph_d;
  logic [7:0] shift_q, shift_d, aux_q, aux_d, periph_q, periph_d;
  logic [FLAG_W-1:0] flags_q, flags_d, en_q, en_d;
  logic [15:0] t1_live, t2_live;
  logic [7:0] rd;
  logic [7:0] wb;

  assign t1_live = (t1_ph_q == PH_RUN) ? t1_cnt_q : 16'd0;
  assign t2_live = (t2_ph_q == PH_RUN) ? t2_cnt_q : 16'd0;
  assign wb      = req_i.write_data;

  always_comb begin
    port_b_d = port_b_q;
    port_a_d = port_a_q;
    dir_b_d  = dir_b_q;
    dir_a_d  = dir_a_q;
    t1_ll_d  = t1_ll_q;
    t1_lh_d  = t1_lh_q;
    t2_ll_d  = t2_ll_q;
    t1_cnt_d = t1_cnt_q;
    t2_cnt_d = t2_cnt_q;
    t1_ph_d  = t1_ph_q;
    t2_ph_d  = t2_ph_q;
    shift_d  = shift_q;
    aux_d    = aux_q;
    periph_d = periph_q;
    flags_d  = flags_q;
    en_d     = en_q;
    rd       = 8'd0;
    case (req_i.action)
      ACT_READ: begin
        case (req_i.reg_index) inside
          REG_PORT_B: rd = port_b_q;
          REG_PORT_A, REG_PORT_A_ALT: rd = port_a_q;
          REG_DIR_B: rd = dir_b_q;
          REG_DIR_A: rd = dir_a_q;
          REG_T1_LOW: begin
            flags_d[FLAG_T1_BIT] = 1'b0;
            rd = t1_live[7:0];
          end
          REG_T1_HIGH: rd = t1_live[15:8];
          REG_T1_LL: rd = t1_ll_q;
          REG_T1_LH: rd = t1_lh_q;
          REG_T2_LOW: begin
            flags_d[FLAG_T2_BIT] = 1'b0;
            rd = t2_live[7:0];
          end
          REG_T2_HIGH: rd = t2_live[15:8];
          REG_SHIFT: rd = shift_q;
          REG_AUX: rd = aux_q;
          REG_PERIPH: rd = periph_q;
          REG_FLAGS: rd = {|(flags_q & en_q), flags_q};
          default: rd = {1'b1, en_q};
        endcase
      end
      ACT_WRITE: begin
        case (req_i.reg_index) inside
          REG_PORT_B: port_b_d = wb;
          REG_PORT_A, REG_PORT_A_ALT: port_a_d = wb;
          REG_DIR_B: dir_b_d = wb;
          REG_DIR_A: dir_a_d = wb;
          REG_T1_LOW, REG_T1_LL: t1_ll_d = wb;
          REG_T1_HIGH: begin
            t1_lh_d  = wb;
            t1_cnt_d = {wb, t1_ll_q};
            t1_ph_d  = PH_RUN;
            flags_d[FLAG_T1_BIT] = 1'b0;
          end
          REG_T1_LH: t1_lh_d = wb;
          REG_T2_LOW: t2_ll_d = wb;
          REG_T2_HIGH: begin
            t2_cnt_d = {wb, t2_ll_q};
            t2_ph_d  = PH_RUN;
            flags_d[FLAG_T2_BIT] = 1'b0;
          end
          REG_SHIFT: shift_d = wb;
          REG_AUX: aux_d = wb;
          REG_PERIPH: periph_d = wb;
          REG_FLAGS: flags_d = flags_q & ~wb[FLAG_W-1:0];
          default: begin
            if (wb[7]) begin
              en_d = en_q | wb[FLAG_W-1:0];
            end else begin
              en_d = en_q & ~wb[FLAG_W-1:0];
            end
          end
        endcase
      end
      ACT_TICK: begin
        if (t1_ph_q == PH_RUN) begin
          if (t1_cnt_q == 16'd0) begin
            t1_ph_d = PH_FIRED;
            flags_d[FLAG_T1_BIT] = 1'b1;
          end else begin
            t1_cnt_d = t1_cnt_q - 16'd1;
          end
        end
        if (t2_ph_q == PH_RUN) begin
          if (t2_cnt_q == 16'd0) begin
            t2_ph_d = PH_FIRED;
            flags_d[FLAG_T2_BIT] = 1'b1;
          end else begin
            t2_cnt_d = t2_cnt_q - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_b_q <= '0;
      port_a_q <= '0;
      dir_b_q  <= '0;
      dir_a_q  <= '0;
      t1_ll_q  <= '0;
      t1_lh_q  <= '0;
      t2_ll_q  <= '0;
      t1_cnt_q <= '0;
      t2_cnt_q <= '0;
      t1_ph_q  <= PH_IDLE;
      t2_ph_q  <= PH_IDLE;
      shift_q  <= '0;
      aux_q    <= '0;
      periph_q <= '0;
      flags_q  <= '0;
      en_q     <= '0;
    end else if (fire_i) begin
      port_b_q <= port_b_d;
      port_a_q <= port_a_d;
      dir_b_q  <= dir_b_d;
      dir_a_q  <= dir_a_d;
      t1_ll_q  <= t1_ll_d;
      t1_lh_q  <= t1_lh_d;
      t2_ll_q  <= t2_ll_d;
      t1_cnt_q <= t1_cnt_d;
      t2_cnt_q <= t2_cnt_d;
      t1_ph_q  <= t1_ph_d;
      t2_ph_q  <= t2_ph_d;
      shift_q  <= shift_d;
      aux_q    <= aux_d;
      periph_q <= periph_d;
      flags_q  <= flags_d;
      en_q     <= en_d;
    end
  end

  assign res_o.read_data = rd;
  assign res_o.irq       = |(flags_d & en_d);

  `VTIR_ASSERT(a_t1_arm, fire_i && req_i.action == ACT_WRITE && req_i.reg_index == REG_T1_HIGH |=> t1_ph_q == PH_RUN && !flags_q[FLAG_T1_BIT], "T1 arm failed")
  `VTIR_ASSERT(a_t1_fire, fire_i && req_i.action == ACT_TICK && t1_ph_q == PH_RUN && t1_cnt_q == 16'd0 |=> t1_ph_q == PH_FIRED && flags_q[FLAG_T1_BIT], "T1 did not fire")
  `VTIR_ASSERT(a_t2_dec, fire_i && req_i.action == ACT_TICK && t2_ph_q == PH_RUN && t2_cnt_q != 16'd0 |=> t2_cnt_q == $past(t2_cnt_q) - 16'd1, "T2 did not count down")
  `VTIR_ASSERT(a_hold, !fire_i |=> $stable(flags_q) && $stable(en_q) && $stable(t1_cnt_q), "state moved without a request")

endmodule

`default_nettype wire

// ----- rtl/vtir_out_stage.sv -----
// ---------------------------------------------------------------------------
// VIA timer register block output stage
// Result register that holds a response until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module vtir_out_stage import vtir_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [7:0] read_data_o,
  output logic      irq_o
);

  logic valid_d, valid_q;
  res_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign read_data_o = res_q.read_data;
  assign irq_o       = res_q.irq;

endmodule

`default_nettype wire
